>>> sv/fma_pkg.sv
// ----------------------------------------------------------------------------
// fma_pkg: shared types and constants of the float32 magnitude adder
// Field widths, masks and the records passed between pipeline stages.
// ----------------------------------------------------------------------------
package fma_pkg;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned EXP_W = 8;
   localparam int unsigned FRAC_W = 23;
   localparam int unsigned MAX_GAP = 24;
   localparam logic [EXP_W-1:0] EXP_MAX = 8'd255;
   localparam logic [WORD_W-1:0] INF_BITS = 32'h7f80_0000;

   // stage 1 to stage 2: ordered operands
   typedef struct packed {
      logic sign;
      logic [30:0] big;
      logic [EXP_W-1:0] eb;
      logic [EXP_W-1:0] gap;
      logic pass;
      logic [FRAC_W:0] mb;
      logic [FRAC_W:0] ms;
      logic big_norm;
      logic small_norm;
   } order_type;

   // stage 2 to stage 3: aligned sum
   typedef struct packed {
      logic sign;
      logic [30:0] big;
      logic pass;
      logic [EXP_W-1:0] eb;
      logic [24:0] sum;
      logic [31:0] rem;
   } align_type;
endpackage

>>> sv/fma_order.sv
// ----------------------------------------------------------------------------
// fma_order: operand ordering stage
// Compares magnitudes, picks the larger operand and computes the exponent gap.
// ----------------------------------------------------------------------------
module fma_order (
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   output fma_pkg::order_type ord
);
   import fma_pkg::*;
   logic [30:0] ma, mbg, big, sml;
   logic [EXP_W-1:0] es;
   always_comb begin
      ma = operand_a[30:0];
      mbg = operand_b[30:0];
      if (ma > mbg) begin
         big = ma;
         sml = mbg;
      end else begin
         big = mbg;
         sml = ma;
      end
      es = sml[30:23];
      ord.sign = operand_a[31];
      ord.big = big;
      ord.eb = big[30:23];
      ord.gap = big[30:23] - es;
      ord.pass = (big[30:23] - es) > EXP_W'(MAX_GAP);
      ord.big_norm = big[30:23] != '0;
      ord.small_norm = es != '0;
      ord.mb = {big[30:23] != '0, big[22:0]};
      ord.ms = {es != '0, sml[22:0]};
   end
endmodule

>>> sv/fma_align.sv
// ----------------------------------------------------------------------------
// fma_align: alignment and add stage
// Shifts the smaller significand, keeps the bits shifted out, adds.
// ----------------------------------------------------------------------------
module fma_align (
   input  fma_pkg::order_type ord,
   output fma_pkg::align_type aln
);
   import fma_pkg::*;
   logic [4:0] sh;
   logic [55:0] wide;
   always_comb begin
      if (ord.big_norm && ord.small_norm) begin
         sh = ord.gap[4:0];
      end else if (ord.big_norm) begin
         sh = 5'(ord.gap - 8'd1);
      end else begin
         sh = '0;
      end
      wide = {ord.ms, 32'd0} >> sh;
      aln.sign = ord.sign;
      aln.big = ord.big;
      aln.pass = ord.pass;
      aln.eb = ord.eb;
      aln.sum = {1'b0, ord.mb} + {1'b0, wide[55:32]};
      aln.rem = wide[31:0];
   end
endmodule

>>> sv/fma_round.sv
// ----------------------------------------------------------------------------
// fma_round: normalise and round stage
// Renormalises on carry, rounds to nearest-even, saturates to infinity.
// ----------------------------------------------------------------------------
module fma_round (
   input  fma_pkg::align_type aln,
   output logic [31:0] sum_bits
);
   import fma_pkg::*;
   logic [8:0] ex;
   logic [31:0] rem;
   logic [22:0] man;
   logic inc;
   always_comb begin
      if (aln.sum[24]) begin
         ex = {1'b0, aln.eb} + 9'd1;
         rem = {aln.sum[0], aln.rem[31:1]};
         man = aln.sum[23:1];
      end else if (aln.sum[23]) begin
         ex = (aln.eb == '0) ? 9'd1 : {1'b0, aln.eb};
         rem = aln.rem;
         man = aln.sum[22:0];
      end else begin
         ex = '0;
         rem = '0;
         man = aln.sum[22:0];
      end
      inc = rem[31] && ((rem[30:0] != '0) || man[0]);
      if (aln.pass) begin
         sum_bits = {aln.sign, aln.big};
      end else if (ex >= {1'b0, EXP_MAX}) begin
         sum_bits = {aln.sign, 31'd0} | INF_BITS;
      end else begin
         sum_bits = {aln.sign, 31'd0} + {1'b0, ex[7:0], man} + 32'(inc);
      end
   end
endmodule

>>> sv/float32_magnitude_adder.sv
// ----------------------------------------------------------------------------
// float32_magnitude_adder: single-precision magnitude adder
//  channel | dir | fields (tdata, low bit first)
//  req_    | in  | operand_a[31:0], operand_b[63:32]
//  rsp_    | out | sum_bits[31:0]
// One item per cycle unless the output stalls; stages: order, align/add, round.
// Synchronous active-high reset clears the stage valid bits.
// A stage advances when its output stage is empty or being taken;
// a stall holds every full stage, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module float32_magnitude_adder (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [63:0] req_tdata,   // operand_a, operand_b
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata    // sum_bits
);
   import fma_pkg::*;
   order_type ord, s1_ff, s1_in;
   align_type aln, s2_ff, s2_in;
   logic [31:0] res, s3_ff, s3_in;
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   fma_order u_order (.operand_a(req_tdata[31:0]), .operand_b(req_tdata[63:32]), .ord(ord));
   fma_align u_align (.ord(s1_ff), .aln(aln));
   fma_round u_round (.aln(s2_ff), .sum_bits(res));

   assign en3 = !v3_ff || rsp_tready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata = s3_ff;
   assign s1_in = ord;
   assign s2_in = aln;
   assign s3_in = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
   end
endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the float32 magnitude adder
// A directed table of operand pairs, then random pairs biased towards small
// exponent gaps, subnormals and overflow, are sent with random gaps.
// Every result is compared with a bit-exact predictor of the sum.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned N_RANDOM = 1200;
   localparam int unsigned IDLE_LIMIT = 20000;
   localparam logic [31:0] NO_CHECK = 32'h0;

   typedef struct {
      logic [31:0] a;
      logic [31:0] b;
      logic known;
      logic [31:0] sum;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   logic [31:0] sums_due[$];
   int unsigned errors = 0;
   int unsigned idle_cycles = 0;
   bit sending_done = 1'b0;

   float32_magnitude_adder u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] round_up(logic lsb, logic [31:0] rem);
      if (rem[31]) begin
         return (rem[30:0] != 0) ? 32'd1 : {31'd0, lsb};
      end
      return 32'd0;
   endfunction

   function automatic logic [31:0] lost_bits(logic [31:0] m, int s);
      if (s == 0 || s > 31) begin
         return 32'd0;
      end
      return m << (32 - s);
   endfunction

   function automatic logic [31:0] magnitude_sum(logic [31:0] a, logic [31:0] b);
      logic [31:0] sgn, big, sml, eb, es, gap, mb, ms, sum, rem, ex, man;
      sgn = {a[31], 31'd0};
      if (a[30:0] > b[30:0]) begin
         big = {1'b0, a[30:0]};
         sml = {1'b0, b[30:0]};
      end else begin
         big = {1'b0, b[30:0]};
         sml = {1'b0, a[30:0]};
      end
      eb = {24'd0, big[30:23]};
      es = {24'd0, sml[30:23]};
      gap = eb - es;
      if (gap > 24) begin
         return sgn | big;
      end
      mb = {8'd0, eb != 0, big[22:0]};
      ms = {8'd0, es != 0, sml[22:0]};
      if (eb != 0 && es != 0) begin
         sum = mb + (ms >> gap);
         rem = lost_bits(ms, gap);
      end else if (eb != 0) begin
         sum = mb + (ms >> (gap - 1));
         rem = lost_bits(ms, gap - 1);
      end else begin
         sum = mb + ms;
         rem = 0;
      end
      if (sum[24]) begin
         ex = eb + 1;
         rem = {sum[0], rem[31:1]};
         man = {9'd0, sum[23:1]};
      end else if (sum[23]) begin
         ex = (eb == 0) ? 32'd1 : eb;
         man = {9'd0, sum[22:0]};
      end else begin
         ex = 0;
         rem = 0;
         man = sum;
      end
      if (ex >= 255) begin
         return sgn | 32'h7f80_0000;
      end
      return sgn + (ex << 23) + man + round_up(man[0], rem);
   endfunction

   function automatic logic [31:0] rand_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: v[30:23] = 8'd0;
         1: v[30:23] = 8'(254 - $urandom_range(0, 3));
         2: v[22:0] = ($urandom_range(0, 1) == 1) ? 23'h7fffff : 23'(1 << $urandom_range(0, 22));
         default: ;
      endcase
      return v;
   endfunction

   task automatic send(logic [31:0] a, logic [31:0] b, logic known, logic [31:0] exp_sum);
      logic [31:0] s;
      s = magnitude_sum(a, b);
      if (known && s !== exp_sum) begin
         errors++;
         if (errors <= 10) begin
            $display("table row %h + %h: predictor %h, table %h", a, b, s, exp_sum);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3))
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, a};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sums_due.push_back(s);
   endtask

   initial begin
      row_type rows[$];
      logic [31:0] a, b, d;
      rows = '{
         '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
         '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
         '{32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'h4000_0000},
         '{32'hbf80_0000, 32'h3f80_0000, 1'b1, 32'hc000_0000},
         '{32'h7f7f_ffff, 32'h7f7f_ffff, 1'b1, 32'h7f80_0000},
         '{32'h7f80_0000, 32'h3f80_0000, 1'b1, 32'h7f80_0000},
         '{32'h7fc0_0000, 32'h0000_0001, 1'b1, 32'h7fc0_0000},
         '{32'h3f80_0000, 32'h0000_0001, 1'b1, 32'h3f80_0000},
         '{32'h4b80_0000, 32'h3f80_0000, 1'b0, NO_CHECK},
         '{32'h4b80_0000, 32'h3f00_0000, 1'b0, NO_CHECK},
         '{32'h4c00_0000, 32'h3f80_0000, 1'b0, NO_CHECK},
         '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0002},
         '{32'h007f_ffff, 32'h0000_0001, 1'b1, 32'h0080_0000},
         '{32'h007f_ffff, 32'h007f_ffff, 1'b0, NO_CHECK},
         '{32'h0080_0000, 32'h0000_0001, 1'b0, NO_CHECK},
         '{32'h0c00_0000, 32'h007f_ffff, 1'b0, NO_CHECK},
         '{32'h3fff_ffff, 32'h3400_0000, 1'b0, NO_CHECK},
         '{32'h3f80_0001, 32'h3380_0000, 1'b0, NO_CHECK},
         '{32'h3f80_0000, 32'h3380_0000, 1'b0, NO_CHECK},
         '{32'h7f7f_ffff, 32'h7380_0000, 1'b0, NO_CHECK},
         '{32'h7f00_0000, 32'h7f00_0000, 1'b1, 32'h7f80_0000},
         '{32'hffff_ffff, 32'hffff_ffff, 1'b0, NO_CHECK},
         '{32'h1234_5678, 32'h8765_4321, 1'b0, NO_CHECK}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         send(rows[i].a, rows[i].b, rows[i].known, rows[i].sum);
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         a = rand_operand();
         b = rand_operand();
         if ($urandom_range(0, 2) != 0) begin
            d = $urandom_range(0, 26);
            b[30:23] = (a[30:23] > d[7:0]) ? a[30:23] - d[7:0] : 8'($urandom_range(0, 2));
         end
         send(a, b, 1'b0, NO_CHECK);
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_tready <= 1'b0;
      end else if (!rsp_tready && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 63) != 0) || rsp_tready;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sums_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected item %h", rsp_tdata);
         end else begin
            if (rsp_tdata !== sums_due[0]) begin
               errors++;
               if (errors <= 10) begin
                  $display("sum_bits mismatch: expected %h, got %h", sums_due[0], rsp_tdata);
               end
            end
            void'(sums_due.pop_front());
         end
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
         if (sending_done && sums_due.size() == 0) begin
            repeat (10) @(posedge clock);
            if (errors == 0 && sums_due.size() == 0) begin
               $display("Verification passed");
            end else begin
               $display("Verification failed");
            end
            $finish;
         end
      end
   end
endmodule
